@@ hdl/assert_macros.svh @@
// assertion helpers shared by the pvb modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PVB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PVB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pvb_pkg.sv @@
package pvb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BUF_W      = 16;
    localparam int VOL_W      = 16;
    localparam int BAL_W      = 16;
    localparam int CHC_W      = 4;
    localparam int FACTOR_W   = 15;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int GAIN_SHIFT = 27;
    localparam int CFG_IDX_W  = 2;

    localparam logic [VOL_W-1:0]        VOL_MAX       = 16'd32768;
    localparam logic signed [BAL_W-1:0] UNITY_BAL     = 16'sd16384;
    localparam logic signed [BAL_W-1:0] NEG_UNITY_BAL = -16'sd16384;

    localparam logic              RST_ENABLE   = 1'b1;
    localparam logic [VOL_W-1:0]  RST_VOLUME   = 16'd8192;
    localparam logic [BAL_W-1:0]  RST_BALANCE  = 16'd0;
    localparam logic [CHC_W-1:0]  RST_CHANNELS = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_VOLUME   = 2'd1,
        CFG_BALANCE  = 2'd2,
        CFG_CHANNELS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_GAIN = 2'd1,
        ST_PROD = 2'd2,
        ST_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [BUF_W-1:0]           buffer_samples;
        logic                       last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last_out;
    } t_out_item;

    typedef struct packed {
        logic                     enable;
        logic [VOL_W-1:0]         volume;
        logic signed [BAL_W-1:0]  balance;
        logic [CHC_W-1:0]         channel_count;
    } t_cfg;

    // per-sample decision from the call tracker
    typedef struct packed {
        logic                scale;
        logic [FACTOR_W-1:0] factor;
    } t_trk;

endpackage

@@ hdl/pvb_track.sv @@
`include "assert_macros.svh"

module pvb_track #(
    parameter int MAX_CHANNELS = 8,
    parameter int COUNT_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pvb_pkg::t_cfg                       i_cfg,
    input  logic                                i_take,
    input  logic [pvb_pkg::BUF_W-1:0]           i_buffer_samples,
    input  logic                                i_last,
    output pvb_pkg::t_trk                       o_trk
);

    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW    = POS_W + 2;
    localparam int CLW   = pvb_pkg::CHC_W + 1;

    logic                  r_in_call;
    logic [POS_W-1:0]      r_pos;
    logic [COUNT_BITS-1:0] r_rem;

    logic [CLW-1:0]             ch_clamp;
    logic [CW-1:0]              ch;
    logic signed [pvb_pkg::BAL_W-1:0] bal;
    logic signed [pvb_pkg::BAL_W-1:0] diff;
    logic [COUNT_BITS-1:0]      rem0;
    logic [COUNT_BITS-1:0]      rem1;
    logic [POS_W-1:0]           pos0;
    logic [CW-1:0]              pos_inc;
    logic [COUNT_BITS:0]        fit_sum;
    logic                       fits;

    always_comb begin
        ch_clamp = ({1'b0, i_cfg.channel_count} > CLW'(MAX_CHANNELS)) ?
                   CLW'(MAX_CHANNELS) : {1'b0, i_cfg.channel_count};
        ch = CW'(ch_clamp);

        if (i_cfg.balance > pvb_pkg::UNITY_BAL) begin
            bal = pvb_pkg::UNITY_BAL;
        end else if (i_cfg.balance < pvb_pkg::NEG_UNITY_BAL) begin
            bal = pvb_pkg::NEG_UNITY_BAL;
        end else begin
            bal = i_cfg.balance;
        end

        // call start reloads the count and restarts the frame
        rem0 = r_in_call ? r_rem : COUNT_BITS'(i_buffer_samples);
        pos0 = r_in_call ? r_pos : '0;

        // the whole frame must fit in what is left of the call
        fit_sum = {1'b0, rem0} + (COUNT_BITS + 1)'(pos0);
        fits    = (fit_sum >= (COUNT_BITS + 1)'(ch));

        o_trk.scale  = i_cfg.enable && (ch != '0) && (rem0 != '0) && fits;
        o_trk.factor = pvb_pkg::FACTOR_W'(pvb_pkg::UNITY_BAL);
        diff         = pvb_pkg::UNITY_BAL;
        if (ch > CW'(1)) begin
            if ((pos0 == '0) && (bal > 16'sd0)) begin
                diff = pvb_pkg::UNITY_BAL - bal;
            end else if ((pos0 == POS_W'(1)) && (bal < 16'sd0)) begin
                diff = pvb_pkg::UNITY_BAL + bal;
            end
        end
        o_trk.factor = diff[pvb_pkg::FACTOR_W-1:0];

        rem1    = (rem0 != '0) ? rem0 - COUNT_BITS'(1) : '0;
        pos_inc = CW'(pos0) + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_call <= 1'b0;
            r_pos     <= '0;
            r_rem     <= '0;
        end else if (i_take) begin
            r_rem <= rem1;
            if (i_last || (rem1 == '0)) begin
                r_in_call <= 1'b0;
                r_pos     <= '0;
            end else begin
                r_in_call <= 1'b1;
                r_pos     <= (pos_inc >= ch) ? '0 : pos_inc[POS_W-1:0];
            end
        end
    end

    `PVB_ASSERT_SAME(a_idle_pos_zero, i_clk, i_rst_n, !r_in_call, r_pos == '0, "position set outside a call")
    `PVB_ASSERT_NEXT(a_last_ends_call, i_clk, i_rst_n, i_take && i_last, !r_in_call, "call did not end on last")

endmodule

@@ hdl/pvb_mul.sv @@
module pvb_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [pvb_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [pvb_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [pvb_pkg::PROD_W-1:0]   o_prod
);

    logic signed [pvb_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // operands sign extended to the product width
            r_prod <= pvb_pkg::PROD_W'(i_a) * pvb_pkg::PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

@@ hdl/pvb_sat.sv @@
module pvb_sat (
    input  logic signed [pvb_pkg::PROD_W-1:0]   i_prod,
    output logic signed [pvb_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int MAG_W = pvb_pkg::PROD_W - 1;
    localparam int Q_W   = MAG_W - pvb_pkg::GAIN_SHIFT;

    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] sum;
    logic [Q_W-1:0]   q;
    logic [Q_W-1:0]   neg_q;

    always_comb begin
        neg   = i_prod[pvb_pkg::PROD_W-1];
        mag   = neg ? MAG_W'(-i_prod) : MAG_W'(i_prod);
        // round half away from zero on the magnitude
        sum   = mag + (MAG_W'(1) << (pvb_pkg::GAIN_SHIFT - 1));
        q     = sum[MAG_W-1:pvb_pkg::GAIN_SHIFT];
        neg_q = Q_W'(0) - q;
        if (neg) begin
            o_sample = (q > Q_W'(32768)) ? 16'sh8000 : neg_q[pvb_pkg::SAMPLE_W-1:0];
        end else begin
            o_sample = (q > Q_W'(32767)) ? 16'sh7fff : q[pvb_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

@@ hdl/pcm_volume_balance_gain.sv @@
// pcm volume and balance gain: scales interleaved signed 16-bit samples by a
// Q3.13 volume and, on the first two channels of a frame, by a Q1.14 balance
// attenuation; products are rounded half away from zero and saturated. One
// item is in flight at a time: a scaled sample goes from accept to output
// register through accept, gain product, sample product, round and store;
// a pass-through sample skips the products. The steps follow the single 17x32
// multiplier, used first for volume times balance factor, then for sample
// times gain. The input stalls while an item is being worked; it accepts the
// next item while the previous result still waits in the output register.
// Samples of a trailing partial frame, short calls and everything while
// disabled pass through unchanged. Registers are written through a plain
// write port and must only change while the block is idle.
`include "assert_macros.svh"

module pcm_volume_balance_gain #(
    parameter int MAX_CHANNELS = 8,
    parameter int COUNT_BITS   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [pvb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pvb_pkg::VOL_W-1:0]          i_cfg_data,
    // input item channel
    input  logic                               i_in_valid,
    input  pvb_pkg::t_in_item                  i_in_item,
    output logic                               o_in_stall,
    // output item channel
    output logic                               o_out_valid,
    output pvb_pkg::t_out_item                 o_out_item,
    input  logic                               i_out_stall
);

    // configuration registers
    pvb_pkg::t_cfg r_cfg;

    // sequencer and captured item
    pvb_pkg::t_state r_state;
    pvb_pkg::t_state n_state;
    logic signed [pvb_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_last;
    logic                                r_scale;
    logic [pvb_pkg::FACTOR_W-1:0]        r_factor;
    logic [pvb_pkg::VOL_W-1:0]           r_vol;

    // output register
    logic               r_out_valid;
    pvb_pkg::t_out_item r_out_item;

    pvb_pkg::t_trk trk;
    logic          take;
    logic          mul_en;
    logic          out_load;
    logic          out_free;
    logic signed [pvb_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [pvb_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [pvb_pkg::PROD_W-1:0]   prod;
    logic signed [pvb_pkg::SAMPLE_W-1:0] scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= pvb_pkg::RST_ENABLE;
            r_cfg.volume        <= pvb_pkg::RST_VOLUME;
            r_cfg.balance       <= pvb_pkg::RST_BALANCE;
            r_cfg.channel_count <= pvb_pkg::RST_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (pvb_pkg::t_cfg_idx'(i_cfg_index))
                pvb_pkg::CFG_ENABLE:   r_cfg.enable        <= i_cfg_data[0];
                pvb_pkg::CFG_VOLUME:   r_cfg.volume        <= i_cfg_data;
                pvb_pkg::CFG_BALANCE:  r_cfg.balance       <= i_cfg_data;
                pvb_pkg::CFG_CHANNELS: r_cfg.channel_count <= i_cfg_data[pvb_pkg::CHC_W-1:0];
            endcase
        end
    end

    // call and frame position tracking, decides scale and balance factor
    pvb_track #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_take           (take),
        .i_buffer_samples (i_in_item.buffer_samples),
        .i_last           (i_in_item.last),
        .o_trk            (trk)
    );

    // operand select for the shared multiplier
    always_comb begin
        if (r_state == pvb_pkg::ST_PROD) begin
            mul_a = {r_sample[pvb_pkg::SAMPLE_W-1], r_sample};
            mul_b = $signed({1'b0, prod[pvb_pkg::MUL_B_W-2:0]});
        end else begin
            mul_a = $signed({1'b0, r_vol});
            mul_b = $signed({{(pvb_pkg::MUL_B_W - pvb_pkg::FACTOR_W){1'b0}}, r_factor});
        end
    end

    pvb_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pvb_sat u_sat (
        .i_prod   (prod),
        .o_sample (scaled)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state    = r_state;
        mul_en     = 1'b0;
        out_load   = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            pvb_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = trk.scale ? pvb_pkg::ST_GAIN : pvb_pkg::ST_DONE;
                end
            end
            pvb_pkg::ST_GAIN: begin
                // gain = volume * balance factor
                mul_en  = 1'b1;
                n_state = pvb_pkg::ST_PROD;
            end
            pvb_pkg::ST_PROD: begin
                // product = sample * gain
                mul_en  = 1'b1;
                n_state = pvb_pkg::ST_DONE;
            end
            pvb_pkg::ST_DONE: begin
                // hold until the output register can take the item
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = pvb_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pvb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the item and its gain decision on accept
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample <= i_in_item.sample_in;
            r_last   <= i_in_item.last;
            r_scale  <= trk.scale;
            r_factor <= trk.factor;
            r_vol    <= (r_cfg.volume > pvb_pkg::VOL_MAX) ? pvb_pkg::VOL_MAX : r_cfg.volume;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.sample_out <= r_scale ? scaled : r_sample;
            r_out_item.last_out   <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PVB_ASSERT_SAME(a_busy_stalls, i_clk, i_rst_n, r_state != pvb_pkg::ST_IDLE, o_in_stall, "input taken while busy")
    `PVB_ASSERT_NEXT(a_gain_then_prod, i_clk, i_rst_n, r_state == pvb_pkg::ST_GAIN, r_state == pvb_pkg::ST_PROD, "gain step not followed by product")
    `PVB_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, r_state == pvb_pkg::ST_DONE && r_out_valid && i_out_stall, r_state == pvb_pkg::ST_DONE, "result dropped while output stalled")
    `PVB_ASSERT_NEXT(a_pass_skips_mul, i_clk, i_rst_n, take && !trk.scale, r_state == pvb_pkg::ST_DONE, "pass-through item went to the multiplier")

endmodule
